/* rtl/lmci_pkg.sv */
package lmci_pkg;

    // Default width of the idle counter that is actually used
    localparam int LMCI_COUNT_WIDTH = 32;

    // Quotient bits of idle*100/peak (always below 100)
    localparam int LMCI_Q_BITS   = 7;
    localparam int LMCI_CNT_BITS = $clog2(LMCI_Q_BITS);

    // Percent scale and smoothing rounding term
    localparam logic [6:0] LMCI_FULL_SCALE = 7'd100;
    localparam logic [8:0] LMCI_ROUND      = 9'd2;

    // Color band thresholds
    localparam logic [6:0] LMCI_TH_GREEN  = 7'd25;
    localparam logic [6:0] LMCI_TH_BLUE   = 7'd50;
    localparam logic [6:0] LMCI_TH_YELLOW = 7'd75;

    // Channel intensities
    localparam logic [5:0] LMCI_LVL_OFF    = 6'd0;
    localparam logic [5:0] LMCI_LVL_MAIN   = 6'd32;
    localparam logic [5:0] LMCI_LVL_YEL_G  = 6'd22;
    localparam logic [5:0] LMCI_LVL_RED    = 6'd40;

    typedef struct packed {
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } rgb_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Pick the indicator color for a smoothed load
    function automatic rgb_t lmci_color(input logic [6:0] load);
        rgb_t c;
        c = '{red: LMCI_LVL_OFF, green: LMCI_LVL_OFF, blue: LMCI_LVL_OFF};
        if (load < LMCI_TH_GREEN) begin
            c.green = LMCI_LVL_MAIN;
        end else if (load < LMCI_TH_BLUE) begin
            c.blue = LMCI_LVL_MAIN;
        end else if (load < LMCI_TH_YELLOW) begin
            c.red   = LMCI_LVL_MAIN;
            c.green = LMCI_LVL_YEL_G;
        end else begin
            c.red = LMCI_LVL_RED;
        end
        return c;
    endfunction

endpackage

/* rtl/lmci_div.sv */
module lmci_div #(
    parameter int COUNT_WIDTH = lmci_pkg::LMCI_COUNT_WIDTH
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [COUNT_WIDTH+lmci_pkg::LMCI_Q_BITS-1:0] dividend,
    input  logic [COUNT_WIDTH-1:0]                   divisor,
    output logic [lmci_pkg::LMCI_Q_BITS-1:0]         quotient,
    output lmci_pkg::div_status_t                    status
);
    import lmci_pkg::*;

    localparam int NW = COUNT_WIDTH + LMCI_Q_BITS;

    logic [NW-1:0]            rem_reg, rem_next;
    logic [NW-1:0]            dvs_reg, dvs_next;
    logic [LMCI_Q_BITS-1:0]   q_reg, q_next;
    logic [LMCI_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic                     fits;
    logic [NW-1:0]            diff;

    // Shared compare/subtract: one quotient bit per cycle
    assign fits = (rem_reg >= dvs_reg);
    assign diff = rem_reg - dvs_reg;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dvs_next  = NW'(divisor) << (LMCI_Q_BITS - 1);
            q_next    = '0;
            cnt_next  = LMCI_CNT_BITS'(LMCI_Q_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff : rem_reg;
            dvs_next = dvs_reg >> 1;
            q_next   = {q_reg[LMCI_Q_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/load_meter_color_indicator.sv */
// Load meter with color indicator. Each request on the slave side carries the
// idle count of one sample window (only the low COUNT_WIDTH bits are used);
// the block tracks the peak idle count, derives the load as
// 100 - floor(idle*100/peak), smooths it as (3*old + raw + 2)/4 and returns
// the smoothed percent with an RGB level set. After acceptance a request
// passes through setup, the 7 steps of the shared restoring divider, the
// divider hand-off and the update; when the division is skipped (peak zero
// or idle not below peak) it goes from setup straight to the update.
// s_tready is high only while no request is in work and returns in the same
// cycle in which the result is posted. A finished result waits in the output
// register until taken and holds the next update, which stalls the block for
// as long as m_tready stays low.
module load_meter_color_indicator #(
    parameter int COUNT_WIDTH = lmci_pkg::LMCI_COUNT_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] idle_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [6:0] smooth_load, [12:7] red_level,
                                   // [18:13] green_level, [24:19] blue_level
);
    import lmci_pkg::*;

    localparam int NW = COUNT_WIDTH + LMCI_Q_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_WIDTH-1:0]  idle_reg, idle_next;
    logic [COUNT_WIDTH-1:0]  peak_reg, peak_next;
    logic                    skip_reg, skip_next;
    logic [6:0]              smooth_reg, smooth_next;
    logic                    mvalid_reg, mvalid_next;
    logic [31:0]             mdata_reg, mdata_next;

    logic [COUNT_WIDTH-1:0]  idle_in;
    logic [NW-1:0]           scaled;
    logic                    div_start;
    logic [LMCI_Q_BITS-1:0]  quot;
    div_status_t             div_st;
    logic [6:0]              raw;
    logic [8:0]              sum;
    logic [6:0]              smooth_new;
    rgb_t                    color;

    assign idle_in = s_tdata[COUNT_WIDTH-1:0];

    // idle * 100 as shift-and-add
    assign scaled = (NW'(idle_reg) << 6) + (NW'(idle_reg) << 5) + (NW'(idle_reg) << 2);

    lmci_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(scaled),
        .divisor (peak_reg),
        .quotient(quot),
        .status  (div_st)
    );

    // Raw load and smoothing
    assign raw        = skip_reg ? 7'd0 : (LMCI_FULL_SCALE - quot);
    assign sum        = {1'b0, smooth_reg, 1'b0} + 9'(smooth_reg) + 9'(raw) + LMCI_ROUND;
    assign smooth_new = sum[8:2];
    assign color      = lmci_color(smooth_new);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        idle_next   = idle_reg;
        peak_next   = peak_reg;
        skip_next   = skip_reg;
        smooth_next = smooth_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        div_start   = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    idle_next  = idle_in;
                    if (idle_in > peak_reg) begin
                        peak_next = idle_in;
                    end
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                skip_next = (peak_reg == '0) || !(idle_reg < peak_reg);
                if ((peak_reg != '0) && (idle_reg < peak_reg)) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                if (div_st.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    smooth_next = smooth_new;
                    mvalid_next = 1'b1;
                    mdata_next  = {7'd0, color.blue, color.green, color.red, smooth_new};
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idle_reg  <= idle_next;
        skip_reg  <= skip_next;
        mdata_reg <= mdata_next;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            peak_reg   <= '0;
            smooth_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            peak_reg   <= peak_next;
            smooth_reg <= smooth_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

/* rtl/lmci_checker.sv */
module lmci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import lmci_pkg::*;

    logic [6:0] load;
    rgb_t       col;

    assign load = m_tdata[6:0];
    assign col  = '{red: m_tdata[12:7], green: m_tdata[18:13], blue: m_tdata[24:19]};

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // One request at a time: busy right after acceptance
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in work");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Load stays in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (load <= LMCI_FULL_SCALE))
        else $error("load above full scale");

    // Color matches the load band
    a_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (col == lmci_color(load)) && (m_tdata[31:25] == 7'd0))
        else $error("color does not match load");

endmodule

bind load_meter_color_indicator lmci_checker u_lmci_checker (.*);
